>>> design/lrgd_pkg.sv
// Shared types, codes and saturating helpers for the gradient descent block.
package lrgd_pkg;

    localparam logic [2:0] FUNC_LOAD_X  = 3'd0;
    localparam logic [2:0] FUNC_LOAD_T  = 3'd1;
    localparam logic [2:0] FUNC_TRAIN   = 3'd2;
    localparam logic [2:0] FUNC_PREDICT = 3'd3;
    localparam logic [2:0] FUNC_READ_W  = 3'd4;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_PRED   = 2'd2;

    localparam logic [1:0] CFG_SAMPLES  = 2'd0;
    localparam logic [1:0] CFG_FEATURES = 2'd1;
    localparam logic [1:0] CFG_STEPS    = 2'd2;
    localparam logic [1:0] CFG_RATE     = 2'd3;

    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    typedef enum logic [1:0] {
        SH_16,
        SH_33,
        SH_48
    } t_shsel;

    typedef struct packed {
        logic [2:0]         func;
        logic [9:0]         sample_index;
        logic [8:0]         feature_index;
        logic signed [31:0] value;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [10:0] sample_count;
        logic [9:0]  feature_count;
        logic [15:0] max_steps;
        logic [47:0] scaled_rate;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [8:0]         index;
        logic signed [63:0] value_res;
        logic [15:0]        steps;
        logic               status;
    } t_result;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic [47:0] clamp_w(input logic signed [63:0] v);
        if (!(&v[63:47] || ~|v[63:47])) begin
            return v[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return v[47:0];
    endfunction

endpackage

>>> design/lrgd_ifs.sv
// Handshake channel interfaces: input items, results and configuration writes.
interface lrgd_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [9:0]         sample_index;
    logic [8:0]         feature_index;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, func, sample_index, feature_index, value, last,
                    input ready);
    modport sink (input valid, func, sample_index, feature_index, value, last,
                  output ready);
endinterface

interface lrgd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [8:0]         index;
    logic signed [63:0] value_res;
    logic [15:0]        steps;
    logic               status;

    modport source (output valid, kind, index, value_res, steps, status, input ready);
    modport sink (input valid, kind, index, value_res, steps, status, output ready);
endinterface

interface lrgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/lrgd_mul.sv
// Shared multiply unit: 64x64 magnitude product in four 32x32 passes, shift, saturate.
module lrgd_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [63:0]    i_a,
    input  logic signed [63:0]    i_b,
    input  lrgd_pkg::t_shsel      i_sh,
    output logic                  o_done,
    output logic signed [63:0]    o_res
);
    import lrgd_pkg::*;

    logic          r_busy, n_busy;
    logic [2:0]    r_cnt, n_cnt;
    logic [63:0]   r_ma, r_mb;
    logic          r_neg;
    t_shsel        r_sh;
    logic [63:0]   r_prod;
    logic [1:0]    r_psh;
    logic          r_pv;
    logic [127:0]  r_acc;
    logic          r_done;
    logic signed [63:0] r_res;

    logic [31:0]   pa, pb;
    logic [1:0]    psh;
    logic [127:0]  addend, q;
    logic signed [63:0] res_c;

    always_comb begin
        case (r_cnt)
            3'd0: begin
                pa = r_ma[31:0]; pb = r_mb[31:0]; psh = 2'd0;
            end
            3'd1: begin
                pa = r_ma[31:0]; pb = r_mb[63:32]; psh = 2'd1;
            end
            3'd2: begin
                pa = r_ma[63:32]; pb = r_mb[31:0]; psh = 2'd1;
            end
            default: begin
                pa = r_ma[63:32]; pb = r_mb[63:32]; psh = 2'd2;
            end
        endcase
        case (r_psh)
            2'd0:    addend = {64'd0, r_prod};
            2'd1:    addend = {32'd0, r_prod, 32'd0};
            default: addend = {r_prod, 64'd0};
        endcase
        case (r_sh)
            SH_16:   q = r_acc >> 16;
            SH_33:   q = r_acc >> 33;
            default: q = r_acc >> 48;
        endcase
        if (|q[127:63]) begin
            res_c = r_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            res_c = r_neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        end
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd5) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_pv   <= r_busy && !i_start && (r_cnt < 3'd4);
            r_done <= r_busy && !i_start && (r_cnt == 3'd5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? 64'd0 - 64'(i_a) : 64'(i_a);
            r_mb  <= i_b[63] ? 64'd0 - 64'(i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_sh;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            r_prod <= pa * pb;
            r_psh  <= psh;
            if (r_pv) begin
                r_acc <= r_acc + addend;
            end
            if (r_cnt == 3'd5) begin
                r_res <= res_c;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> design/lrgd_core.sv
// Sequencer, sample/weight stores and training loop around the shared multiplier.
module lrgd_core #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lrgd_pkg::t_item   i_item,
    input  lrgd_pkg::t_cfg    i_cfg,
    output logic              o_idle,
    output logic              o_res_valid,
    output lrgd_pkg::t_result o_res
);
    import lrgd_pkg::*;

    localparam int SW    = $clog2(MAX_SAMPLES);
    localparam int FW    = $clog2(MAX_FEATURES);
    localparam int DEPTH = MAX_SAMPLES * MAX_FEATURES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [21:0] {
        S_CLR    = 22'd1 << 0,
        S_IDLE   = 22'd1 << 1,
        S_RDW    = 22'd1 << 2,
        S_P_MS   = 22'd1 << 3,
        S_P_MW   = 22'd1 << 4,
        S_P_BW   = 22'd1 << 5,
        S_SW_RD  = 22'd1 << 6,
        S_SW_MS  = 22'd1 << 7,
        S_SW_MW  = 22'd1 << 8,
        S_SW_E   = 22'd1 << 9,
        S_SW_EW  = 22'd1 << 10,
        S_SW_END = 22'd1 << 11,
        S_G_RD   = 22'd1 << 12,
        S_G_MS   = 22'd1 << 13,
        S_G_MW   = 22'd1 << 14,
        S_U_RD   = 22'd1 << 15,
        S_U_MS   = 22'd1 << 16,
        S_U_MW   = 22'd1 << 17,
        S_R_RD   = 22'd1 << 18,
        S_R_WR   = 22'd1 << 19,
        S_DONE   = 22'd1 << 20,
        S_SPARE  = 22'd1 << 21
    } t_state;

    // stores
    logic [31:0] smem [DEPTH];
    logic [31:0] tmem [MAX_SAMPLES];
    logic [47:0] wmem [MAX_FEATURES];
    logic [47:0] vmem [MAX_FEATURES];
    logic [63:0] gmem [MAX_FEATURES];
    logic [63:0] rmem [MAX_SAMPLES];

    logic          x_we, x_re;
    logic [AW-1:0] x_wa, x_ra;
    logic [31:0]   x_wd, x_rd;
    logic          t_we, t_re;
    logic [SW-1:0] t_wa, t_ra;
    logic [31:0]   t_wd, t_rd;
    logic          w_we, w_re;
    logic [FW-1:0] w_wa, w_ra;
    logic [47:0]   w_wd, w_rd;
    logic          v_we, v_re;
    logic [FW-1:0] v_wa, v_ra;
    logic [47:0]   v_wd, v_rd;
    logic          g_we, g_re;
    logic [FW-1:0] g_wa, g_ra;
    logic [63:0]   g_wd, g_rd;
    logic          e_we, e_re;
    logic [SW-1:0] e_wa, e_ra;
    logic [63:0]   e_wd, e_rd;

    t_state             r_state, n_state;
    logic [FW-1:0]      r_j, n_j;
    logic [SW-1:0]      r_i, n_i;
    logic [AW-1:0]      r_row, n_row;
    logic signed [63:0] r_h, n_h, r_cost, n_cost, r_cur, n_cur, r_psum, n_psum;
    logic [15:0]        r_s, n_s, r_limit, n_limit;
    logic               r_status, n_status, r_first, n_first;
    logic [SW-1:0]      r_ns, n_ns;
    logic [FW-1:0]      r_nf, n_nf;
    t_item              r_item, n_item;

    logic               mul_start, mul_done;
    logic signed [63:0] mul_a, mul_b, mul_res;
    t_shsel             mul_sh;

    logic [31:0]        si32, fi32, sc32, fc32, la32;
    logic signed [63:0] w_ext, x_ext, e_val;
    logic               load_x_ok, fi_ok, pred_ok, j_end, i_end;

    lrgd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_sh    (mul_sh),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (x_we) smem[x_wa] <= x_wd;
        if (x_re) x_rd <= smem[x_ra];
        if (t_we) tmem[t_wa] <= t_wd;
        if (t_re) t_rd <= tmem[t_ra];
        if (w_we) wmem[w_wa] <= w_wd;
        if (w_re) w_rd <= wmem[w_ra];
        if (v_we) vmem[v_wa] <= v_wd;
        if (v_re) v_rd <= vmem[v_ra];
        if (g_we) gmem[g_wa] <= g_wd;
        if (g_re) g_rd <= gmem[g_ra];
        if (e_we) rmem[e_wa] <= e_wd;
        if (e_re) e_rd <= rmem[e_ra];
    end

    assign si32  = 32'(i_item.sample_index);
    assign fi32  = 32'(i_item.feature_index);
    assign sc32  = 32'(i_cfg.sample_count);
    assign fc32  = 32'(i_cfg.feature_count);
    assign la32  = si32 * 32'(MAX_FEATURES) + fi32;
    assign load_x_ok = (si32 < 32'(MAX_SAMPLES)) && (fi32 < 32'(MAX_FEATURES))
                       && (fi32 != 32'd0);
    assign fi_ok   = fi32 < 32'(MAX_FEATURES);
    assign pred_ok = fi_ok && (fi32 != 32'd0) && (fi32 < fc32);
    assign w_ext = {{16{w_rd[47]}}, w_rd};
    assign x_ext = (r_j == '0) ? ONE_Q16 : 64'($signed(x_rd));
    assign e_val = sat_sub({{16{t_rd[31]}}, t_rd, 16'd0}, r_h);
    assign j_end = (r_j == r_nf);
    assign i_end = (r_i == r_ns);

    always_comb begin
        n_state = r_state; n_j = r_j; n_i = r_i; n_row = r_row;
        n_h = r_h; n_cost = r_cost; n_cur = r_cur; n_psum = r_psum;
        n_s = r_s; n_limit = r_limit; n_status = r_status; n_first = r_first;
        n_ns = r_ns; n_nf = r_nf; n_item = r_item;
        x_we = 1'b0; x_re = 1'b0; x_wa = la32[AW-1:0]; x_ra = r_row + AW'(r_j);
        x_wd = i_item.value;
        t_we = 1'b0; t_re = 1'b0; t_wa = si32[SW-1:0]; t_ra = r_i; t_wd = i_item.value;
        w_we = 1'b0; w_re = 1'b0; w_wa = r_j; w_ra = r_j; w_wd = '0;
        v_we = 1'b0; v_re = 1'b0; v_wa = r_j; v_ra = r_j; v_wd = w_rd;
        g_we = 1'b0; g_re = 1'b0; g_wa = r_j; g_ra = r_j; g_wd = '0;
        e_we = 1'b0; e_re = 1'b0; e_wa = r_i; e_ra = r_i; e_wd = e_val;
        mul_start = 1'b0; mul_a = w_ext; mul_b = x_ext; mul_sh = SH_16;
        o_res_valid = 1'b0;
        o_res = '0;

        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                if (32'(r_j) == 32'(MAX_FEATURES - 1)) begin
                    n_j = '0;
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    case (i_item.func)
                        FUNC_LOAD_X: x_we = load_x_ok;
                        FUNC_LOAD_T: t_we = si32 < 32'(MAX_SAMPLES);
                        FUNC_TRAIN: begin
                            n_ns = (sc32 == 32'd0) ? '0 :
                                   (sc32 > 32'(MAX_SAMPLES)) ? SW'(MAX_SAMPLES - 1) :
                                   SW'(sc32 - 32'd1);
                            n_nf = (fc32 == 32'd0) ? '0 :
                                   (fc32 > 32'(MAX_FEATURES)) ? FW'(MAX_FEATURES - 1) :
                                   FW'(fc32 - 32'd1);
                            n_limit = (i_cfg.max_steps == 16'd0) ? 16'd1 : i_cfg.max_steps;
                            n_i = '0; n_j = '0; n_row = '0; n_h = '0; n_cost = '0;
                            n_first = 1'b1; n_s = 16'd1; n_status = 1'b0;
                            n_state = S_SW_RD;
                        end
                        FUNC_PREDICT: begin
                            if (pred_ok) begin
                                w_re = 1'b1; w_ra = fi32[FW-1:0];
                                n_state = S_P_MS;
                            end else if (i_item.last) begin
                                w_re = 1'b1; w_ra = '0;
                                n_state = S_P_BW;
                            end
                        end
                        FUNC_READ_W: begin
                            w_re = fi_ok; w_ra = fi32[FW-1:0];
                            n_state = S_RDW;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RDW: begin
                o_res_valid = 1'b1;
                o_res.kind = KIND_WEIGHT;
                o_res.index = r_item.feature_index;
                o_res.value_res = (32'(r_item.feature_index) < 32'(MAX_FEATURES)) ?
                                  w_ext : '0;
                n_state = S_IDLE;
            end
            S_P_MS: begin
                mul_start = 1'b1; mul_b = 64'(r_item.value);
                n_state = S_P_MW;
            end
            S_P_MW: begin
                if (mul_done) begin
                    n_psum = sat_add(r_psum, mul_res);
                    if (r_item.last) begin
                        w_re = 1'b1; w_ra = '0;
                        n_state = S_P_BW;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_P_BW: begin
                o_res_valid = 1'b1;
                o_res.kind = KIND_PRED;
                o_res.value_res = sat_add(r_psum, w_ext);
                n_psum = '0;
                n_state = S_IDLE;
            end
            S_SW_RD: begin
                w_re = 1'b1; x_re = 1'b1; t_re = 1'b1;
                n_state = S_SW_MS;
            end
            S_SW_MS: begin
                mul_start = 1'b1;
                n_state = S_SW_MW;
            end
            S_SW_MW: begin
                if (mul_done) begin
                    n_h = sat_add(r_h, mul_res);
                    if (j_end) begin
                        n_state = S_SW_E;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_SW_RD;
                    end
                end
            end
            S_SW_E: begin
                e_we = 1'b1;
                mul_start = 1'b1; mul_a = e_val; mul_b = e_val; mul_sh = SH_33;
                n_state = S_SW_EW;
            end
            S_SW_EW: begin
                if (mul_done) begin
                    n_cost = sat_add(r_cost, mul_res);
                    if (i_end) begin
                        n_state = S_SW_END;
                    end else begin
                        n_i = r_i + 1'b1; n_j = '0; n_h = '0;
                        n_row = r_row + AW'(MAX_FEATURES);
                        n_state = S_SW_RD;
                    end
                end
            end
            S_SW_END: begin
                n_i = '0; n_j = '0; n_row = '0;
                if (r_first) begin
                    n_cur = r_cost; n_first = 1'b0;
                    n_state = S_G_RD;
                end else if (r_s != 16'd1 && r_cur <= r_cost) begin
                    n_status = 1'b1;
                    n_state = S_R_RD;
                end else begin
                    n_cur = r_cost;
                    if (r_s == r_limit) begin
                        n_state = S_DONE;
                    end else begin
                        n_s = r_s + 16'd1;
                        n_state = S_G_RD;
                    end
                end
            end
            S_G_RD: begin
                e_re = 1'b1; x_re = 1'b1; g_re = 1'b1;
                n_state = S_G_MS;
            end
            S_G_MS: begin
                mul_start = 1'b1; mul_a = e_rd;
                n_state = S_G_MW;
            end
            S_G_MW: begin
                if (mul_done) begin
                    g_we = 1'b1;
                    g_wd = sat_add((r_i == '0) ? 64'sd0 : g_rd, mul_res);
                    if (j_end) begin
                        n_j = '0;
                        if (i_end) begin
                            n_state = S_U_RD;
                        end else begin
                            n_i = r_i + 1'b1;
                            n_row = r_row + AW'(MAX_FEATURES);
                            n_state = S_G_RD;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_G_RD;
                    end
                end
            end
            S_U_RD: begin
                w_re = 1'b1; g_re = 1'b1;
                n_state = S_U_MS;
            end
            S_U_MS: begin
                v_we = 1'b1;
                mul_start = 1'b1; mul_a = {16'd0, i_cfg.scaled_rate}; mul_b = g_rd;
                mul_sh = SH_48;
                n_state = S_U_MW;
            end
            S_U_MW: begin
                if (mul_done) begin
                    w_we = 1'b1;
                    w_wd = clamp_w(sat_add(w_ext, mul_res));
                    if (j_end) begin
                        n_i = '0; n_j = '0; n_row = '0; n_h = '0; n_cost = '0;
                        n_state = S_SW_RD;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_U_RD;
                    end
                end
            end
            S_R_RD: begin
                v_re = 1'b1;
                n_state = S_R_WR;
            end
            S_R_WR: begin
                w_we = 1'b1; w_wd = v_rd;
                if (j_end) begin
                    n_state = S_DONE;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_R_RD;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                o_res.kind = KIND_DONE;
                o_res.value_res = r_cur;
                o_res.steps = r_s;
                o_res.status = r_status;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_j     <= '0;
            r_psum  <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_psum  <= n_psum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_row <= n_row; r_h <= n_h; r_cost <= n_cost; r_cur <= n_cur;
        r_s <= n_s; r_limit <= n_limit; r_status <= n_status; r_first <= n_first;
        r_ns <= n_ns; r_nf <= n_nf; r_item <= n_item;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

>>> design/linear_regression_gradient_descent.sv
// A predict item with a feature index in range takes one multiply; one with last also adds the bias.
// Train does each multiply as a store read, a multiplier start and a wait for done, and
// needs (2*ns*nf + ns + nf) multiplies per step plus an initial sweep of (ns*nf + ns),
// all on the single shared four-pass 64x64 multiplier.
// At most one item in flight; ready drops while an item is being worked on.
// After reset the weight store is cleared before any item is taken.
module linear_regression_gradient_descent #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_FEATURES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrgd_in_if.sink     i_in,
    lrgd_cfg_if.sink    i_cfg,
    lrgd_out_if.source  o_out
);
    import lrgd_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_result res, r_out;
    logic    idle, res_valid, start, r_out_valid;

    assign item = '{func: i_in.func, sample_index: i_in.sample_index,
                    feature_index: i_in.feature_index, value: i_in.value,
                    last: i_in.last};
    assign i_in.ready = idle && (!r_out_valid || o_out.ready);
    assign start = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sample_count: 11'd1024, feature_count: 10'd385,
                       max_steps: 16'd10000, scaled_rate: 48'd1125900};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SAMPLES:  r_cfg.sample_count  <= i_cfg.data[10:0];
                CFG_FEATURES: r_cfg.feature_count <= i_cfg.data[9:0];
                CFG_STEPS:    r_cfg.max_steps     <= i_cfg.data[15:0];
                CFG_RATE:     r_cfg.scaled_rate   <= i_cfg.data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    lrgd_core #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .i_cfg       (r_cfg),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out.kind;
    assign o_out.index     = r_out.index;
    assign o_out.value_res = r_out.value_res;
    assign o_out.steps     = r_out.steps;
    assign o_out.status    = r_out.status;

endmodule

>>> tb/sv/linear_regression_gradient_descent_test.sv
// Self-checking testbench for the linear regression gradient descent block.
module linear_regression_gradient_descent_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lrgd_pkg::*;

    localparam int N_SAMP = 1024;
    localparam int N_FEAT = 512;
    localparam logic signed [63:0] Q_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] Q_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] W_MIN = -W_MAX - 64'sd1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lrgd_in_if  in_ch ();
    lrgd_cfg_if cfg_ch ();
    lrgd_out_if out_ch ();

    linear_regression_gradient_descent u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] x_mem [0:N_SAMP-1][0:N_FEAT-1];
    logic signed [31:0] t_mem [0:N_SAMP-1];
    logic signed [63:0] wgt [0:N_FEAT-1];
    logic signed [63:0] wgt_saved [0:N_FEAT-1];
    logic signed [63:0] grad [0:N_FEAT-1];
    logic signed [63:0] resid [0:N_SAMP-1];
    logic signed [63:0] last_cost;
    logic signed [63:0] dot_acc;
    logic [10:0] reg_ns;
    logic [9:0]  reg_nf;
    logic [15:0] reg_steps;
    logic [47:0] reg_rate;

    t_item   send_q [$];
    t_result results_due [$];
    int      err_count = 0;
    int      rand_sent = 0;
    logic    in_taken = 1'b0;
    int      gap_left = 0;
    int      burst_left = 0;
    int      hold_ask = 0;
    int      hold_seen = 0;
    int      hold_left = 0;
    int      rdy_mode = 0;
    int      rdy_cnt = 0;

    function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] w_clamp(input logic signed [63:0] v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    // (a*b) >> sh, truncated toward zero, saturated
    function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int sh);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        logic         neg;
        neg = a[63] ^ b[63];
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p = ({64'd0, ma} * {64'd0, mb}) >> sh;
        if (!neg) return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? Q_MAX : p[63:0];
        if (p >= 128'h8000_0000_0000_0000) return Q_MIN;
        return -$signed(p[63:0]);
    endfunction

    function automatic logic signed [63:0] feat(input int i, input int j);
        if (j == 0) return ONE_Q16;
        return 64'(x_mem[i][j]);
    endfunction

    function automatic logic signed [63:0] residual_sweep(input int ns, input int nf);
        logic signed [63:0] cost, h, e;
        cost = '0;
        for (int i = 0; i < ns; i++) begin
            h = '0;
            for (int j = 0; j < nf; j++) h = q_add(h, q_mul(wgt[j], feat(i, j), 16));
            e = q_sub(64'(t_mem[i]) * ONE_Q16, h);
            resid[i] = e;
            cost = q_add(cost, q_mul(e, e, 33));
        end
        return cost;
    endfunction

    function automatic t_result descend(input int dummy);
        int ns, nf, lim, taken;
        logic st;
        logic signed [63:0] cur, prev;
        t_result r;
        ns = (reg_ns < 1) ? 1 : ((reg_ns > N_SAMP) ? N_SAMP : int'(reg_ns));
        nf = (reg_nf < 1) ? 1 : ((reg_nf > N_FEAT) ? N_FEAT : int'(reg_nf));
        lim = (reg_steps == 0) ? 1 : int'(reg_steps);
        taken = 0;
        st = 1'b0;
        cur = residual_sweep(ns, nf);
        for (int s = 1; s <= lim; s++) begin
            for (int j = 0; j < nf; j++) begin
                wgt_saved[j] = wgt[j];
                grad[j] = '0;
            end
            for (int i = 0; i < ns; i++)
                for (int j = 0; j < nf; j++)
                    grad[j] = q_add(grad[j], q_mul(resid[i], feat(i, j), 16));
            for (int j = 0; j < nf; j++)
                wgt[j] = w_clamp(q_add(wgt[j], q_mul({16'd0, reg_rate}, grad[j], 48)));
            prev = cur;
            cur = residual_sweep(ns, nf);
            taken = s;
            if (s > 1 && prev <= cur) begin
                for (int j = 0; j < nf; j++) wgt[j] = wgt_saved[j];
                cur = prev;
                st = 1'b1;
                break;
            end
        end
        last_cost = cur;
        r.kind = KIND_DONE;
        r.index = '0;
        r.value_res = cur;
        r.steps = 16'(taken);
        r.status = st;
        return r;
    endfunction

    task automatic apply_item(input t_item it);
        t_result r;
        r = '0;
        case (it.func)
            FUNC_LOAD_X: if (it.feature_index != 0)
                x_mem[it.sample_index][it.feature_index] = it.value;
            FUNC_LOAD_T: t_mem[it.sample_index] = it.value;
            FUNC_TRAIN: results_due.push_back(descend(0));
            FUNC_PREDICT: begin
                if (it.feature_index != 0 && it.feature_index < reg_nf)
                    dot_acc = q_add(dot_acc, q_mul(wgt[it.feature_index], 64'(it.value), 16));
                if (it.last) begin
                    r.kind = KIND_PRED;
                    r.value_res = q_add(dot_acc, wgt[0]);
                    dot_acc = '0;
                    results_due.push_back(r);
                end
            end
            FUNC_READ_W: begin
                r.kind = KIND_WEIGHT;
                r.index = it.feature_index;
                r.value_res = wgt[it.feature_index];
                results_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // input acceptance, predictor and result checking
    always @(posedge i_clk) begin
        t_item   it;
        t_result w;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            it.func = in_ch.func;
            it.sample_index = in_ch.sample_index;
            it.feature_index = in_ch.feature_index;
            it.value = in_ch.value;
            it.last = in_ch.last;
            apply_item(it);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_ch.kind), 64'd0);
            end else begin
                w = results_due.pop_front();
                if (out_ch.kind != w.kind) report_mismatch("kind", 64'(out_ch.kind), 64'(w.kind));
                if (out_ch.index != w.index)
                    report_mismatch("index", 64'(out_ch.index), 64'(w.index));
                if (out_ch.value_res != w.value_res)
                    report_mismatch("value_res", out_ch.value_res, w.value_res);
                if (out_ch.steps != w.steps)
                    report_mismatch("steps", 64'(out_ch.steps), 64'(w.steps));
                if (out_ch.status != w.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(w.status));
            end
        end
    end

    // item driver: bursts with random gaps
    always @(negedge i_clk) begin
        t_item it;
        if (!in_ch.valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                it = send_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.func <= it.func;
                in_ch.sample_index <= it.sample_index;
                in_ch.feature_index <= it.feature_index;
                in_ch.value <= it.value;
                in_ch.last <= it.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern plus requested long hold-offs
    always @(negedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            if (rdy_cnt == 0) rdy_mode <= $urandom_range(0, 2);
            rdy_cnt <= (rdy_cnt + 1) % 80;
            case (rdy_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic push_item(input logic [2:0] f, input logic [9:0] si, input logic [8:0] fi,
                             input logic [31:0] v, input logic l);
        t_item it;
        it.func = f;
        it.sample_index = si;
        it.feature_index = fi;
        it.value = v;
        it.last = l;
        send_q.push_back(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SAMPLES:  reg_ns = d[10:0];
            CFG_FEATURES: reg_nf = d[9:0];
            CFG_STEPS:    reg_steps = d[15:0];
            default:      reg_rate = d;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        wait (send_q.size() == 0 && !in_ch.valid && results_due.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            4: return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    // load every sample and target that a train can read
    task automatic fill_data(input int ns, input int nf);
        for (int i = 0; i < ns; i++) begin
            push_item(FUNC_LOAD_T, 10'(i), 9'($urandom), pick_value(), 1'($urandom));
            for (int j = 1; j < nf; j++)
                push_item(FUNC_LOAD_X, 10'(i), 9'(j), pick_value(), 1'($urandom));
        end
    endtask

    task automatic random_item(input int ns, input int nf);
        int r;
        logic [9:0] si;
        logic [8:0] fi;
        r = $urandom_range(0, 99);
        si = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, ns - 1));
        fi = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, nf));
        if (r < 28)      push_item(FUNC_LOAD_X, si, fi, pick_value(), 1'($urandom));
        else if (r < 38) push_item(FUNC_LOAD_T, si, fi, pick_value(), 1'($urandom));
        else if (r < 41) push_item(FUNC_TRAIN, 10'($urandom), 9'($urandom), $urandom,
                                   1'($urandom));
        else if (r < 75) push_item(FUNC_PREDICT, 10'($urandom), fi, pick_value(),
                                   $urandom_range(0, 2) == 0);
        else if (r < 97) push_item(FUNC_READ_W, 10'($urandom), fi, $urandom, 1'($urandom));
        else push_item(3'($urandom_range(5, 7)), 10'($urandom), 9'($urandom), $urandom,
                       1'($urandom));
        rand_sent++;
    endtask

    initial begin
        int ns, nf, phase;
        logic [47:0] rate;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.sample_index = '0;
        in_ch.feature_index = '0;
        in_ch.value = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int j = 0; j < N_FEAT; j++) wgt[j] = '0;
        last_cost = '0;
        dot_acc = '0;
        reg_ns = 11'd1024;
        reg_nf = 10'd385;
        reg_steps = 16'd10000;
        reg_rate = 48'd1125900;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads, predict column cases, ignored codes, index extremes
        push_item(FUNC_READ_W, 10'd0, 9'd0, 32'd0, 1'b0);
        push_item(FUNC_READ_W, 10'h3FF, 9'd511, 32'hFFFF_FFFF, 1'b1);
        push_item(FUNC_PREDICT, 10'd0, 9'd0, 32'h7FFF_FFFF, 1'b1);
        push_item(FUNC_PREDICT, 10'h3FF, 9'd384, 32'h8000_0000, 1'b0);
        push_item(FUNC_PREDICT, 10'd0, 9'd385, 32'h7FFF_FFFF, 1'b1);
        push_item(3'd5, 10'h3FF, 9'h1FF, 32'hFFFF_FFFF, 1'b1);
        push_item(3'd6, 10'd0, 9'd0, 32'd0, 1'b0);
        push_item(3'd7, 10'h2AA, 9'h155, 32'h5555_5555, 1'b1);
        push_item(FUNC_LOAD_X, 10'h3FF, 9'd511, 32'h8000_0000, 1'b1);
        push_item(FUNC_LOAD_X, 10'd0, 9'd0, 32'h7FFF_FFFF, 1'b0);
        push_item(FUNC_LOAD_T, 10'h3FF, 9'h1FF, 32'h7FFF_FFFF, 1'b1);
        settle();

        // registers below range, rate at maximum
        write_reg(CFG_SAMPLES, 48'd0);
        write_reg(CFG_FEATURES, 48'd0);
        write_reg(CFG_STEPS, 48'd0);
        write_reg(CFG_RATE, 48'hFFFF_FFFF_FFFF);
        push_item(FUNC_LOAD_T, 10'd0, 9'd0, 32'h0003_0000, 1'b0);
        push_item(FUNC_TRAIN, 10'd0, 9'd0, 32'd0, 1'b0);
        push_item(FUNC_READ_W, 10'd0, 9'd0, 32'd0, 1'b0);
        push_item(FUNC_PREDICT, 10'd0, 9'd1, 32'h0001_0000, 1'b1);
        settle();

        // all samples, one feature
        write_reg(CFG_SAMPLES, 48'd2047);
        write_reg(CFG_FEATURES, 48'd1);
        write_reg(CFG_STEPS, 48'd1);
        write_reg(CFG_RATE, 48'd1 << 30);
        fill_data(N_SAMP, 1);
        push_item(FUNC_TRAIN, 10'd0, 9'd0, 32'd0, 1'b0);
        push_item(FUNC_READ_W, 10'd0, 9'd0, 32'd0, 1'b0);
        settle();

        // all features, one sample
        write_reg(CFG_SAMPLES, 48'd1);
        write_reg(CFG_FEATURES, 48'd1023);
        write_reg(CFG_STEPS, 48'd2);
        write_reg(CFG_RATE, 48'd1 << 36);
        fill_data(1, N_FEAT);
        push_item(FUNC_TRAIN, 10'd0, 9'd0, 32'd0, 1'b0);
        push_item(FUNC_READ_W, 10'd0, 9'd511, 32'd0, 1'b0);
        push_item(FUNC_PREDICT, 10'd0, 9'd511, 32'h0002_0000, 1'b0);
        push_item(FUNC_PREDICT, 10'd0, 9'd1, 32'hFFFF_0000, 1'b1);
        settle();

        // zero rate: cost holds, stops on the second step
        write_reg(CFG_SAMPLES, 48'd2);
        write_reg(CFG_FEATURES, 48'd2);
        write_reg(CFG_STEPS, 48'd65535);
        write_reg(CFG_RATE, 48'd0);
        fill_data(2, 2);
        push_item(FUNC_TRAIN, 10'd0, 9'd0, 32'd0, 1'b0);
        settle();

        phase = 0;
        while (rand_sent < 200) begin
            ns = $urandom_range(1, 4);
            nf = $urandom_range(1, 4);
            case ($urandom_range(0, 4))
                0: rate = 48'd0;
                1: rate = 48'hFFFF_FFFF_FFFF;
                2: rate = {16'($urandom), 32'($urandom)};
                default: rate = 48'($urandom_range(1, 1 << 12)) << 32;
            endcase
            write_reg(CFG_SAMPLES, 48'(ns));
            write_reg(CFG_FEATURES, 48'(nf));
            write_reg(CFG_STEPS, 48'($urandom_range(1, 8)));
            write_reg(CFG_RATE, rate);
            fill_data(ns, nf);
            if (phase % 7 == 2) hold_ask++;
            for (int k = 0; k < 70; k++) random_item(ns, nf);
            settle();
            phase++;
        end

        repeat (200) @(posedge i_clk);
        if (results_due.size() != 0)
            report_mismatch("results never arrived", 64'(results_due.size()), 64'd0);
        if (err_count == 0) begin
            $display("linear_regression_gradient_descent verification clean");
        end else begin
            $display("linear_regression_gradient_descent verification failed");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("linear_regression_gradient_descent verification failed");
        $finish;
    end

endmodule
